@@ rtl/core/silu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package silu_pkg;

  // number formats
  localparam int DATA_WIDTH       = 16;
  localparam int FRAC_BITS        = 12;
  localparam int SIGMOID_SEGMENTS = 64;
  localparam int SIG_BITS         = 30;
  localparam int SPAN_SHIFT       = FRAC_BITS + 3;

  // derived widths
  localparam int IDX_W   = $clog2(SIGMOID_SEGMENTS + 1);
  localparam int POS_W   = DATA_WIDTH + IDX_W;
  localparam int KNOT_W  = SIG_BITS + 1;
  localparam int S_W     = SIG_BITS + 1;
  localparam int FWD_W   = DATA_WIDTH + S_W + 1;
  localparam int SIGP_W  = 2 * S_W;
  localparam int TPROD_W = DATA_WIDTH + S_W + 1;
  localparam int D_W     = SIG_BITS + 3;
  localparam int DG_W    = D_W + DATA_WIDTH;
  localparam int Y_W     = DG_W - SIG_BITS + 1;
  localparam int WIDE_W  = 128;

  // stream widths, padded to whole bytes
  localparam int TDATA_IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int TDATA_OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [S_W-1:0] SIG_ONE = S_W'(64'd1 << SIG_BITS);

  localparam logic signed [D_W-1:0] DERIV_MAX = D_W'(64'sd2 <<< SIG_BITS);
  localparam logic signed [D_W-1:0] DERIV_MIN = -DERIV_MAX;

  localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

  // exp series step in Q30: 8 / segments, rounded
  localparam logic [63:0] STEP_A =
    ((64'd8 << SIG_BITS) + 64'(SIGMOID_SEGMENTS / 2)) / 64'(SIGMOID_SEGMENTS);

  typedef enum logic {
    OP_FORWARD  = 1'b0,
    OP_BACKWARD = 1'b1
  } op_t;

  typedef struct packed {
    op_t                          op;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] g;
  } item_t;

  typedef logic [KNOT_W-1:0] knot_tab_t [SIGMOID_SEGMENTS + 1];

  // shift-subtract division, used only while building the knot table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid knots in Q30 at |x| = 8k / segments
  function automatic knot_tab_t build_knots();
    knot_tab_t          tab;
    logic [63:0]        term;
    logic [63:0]        e;
    logic [63:0]        q;
    logic [63:0]        d;
    logic signed [63:0] sum;
    term = 64'd1 << SIG_BITS;
    e    = 64'd1 << SIG_BITS;
    sum  = 64'sd1 <<< SIG_BITS;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = udiv64((term * STEP_A) >> SIG_BITS, 64'(n));
        if (n[0]) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    q = (sum < 0) ? 64'd0 : $unsigned(sum);
    for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
      if (k > 0) begin
        e = (e * q + (64'd1 << (SIG_BITS - 1))) >> SIG_BITS;
      end
      d      = (64'd1 << SIG_BITS) + e;
      tab[k] = KNOT_W'(udiv64((64'd1 << (2 * SIG_BITS)) + (d >> 1), d));
    end
    return tab;
  endfunction

  localparam knot_tab_t KNOT_TABLE = build_knots();

  // arithmetic right shift, rounding half away from zero
  function automatic logic signed [WIDE_W-1:0] round_shr(
    input logic signed [WIDE_W-1:0] v,
    input int unsigned              sh
  );
    logic signed [WIDE_W-1:0] half;
    logic signed [WIDE_W-1:0] sum;
    half = 1;
    half = half <<< (sh - 1);
    sum  = v + half;
    if (v < 0) begin
      sum = sum - 1;
    end
    return sum >>> sh;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/silu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module silu_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire silu_pkg::item_t in_item,
  output logic                 head_valid,
  output silu_pkg::item_t      head_item,
  input  wire logic            pop
);
  import silu_pkg::*;

  item_t             slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              take;
  item_t             classified;

  // classify: keep the low opcode bit, drop the gradient for forward items
  always_comb begin
    classified    = in_item;
    classified.op = op_t'(in_item.op);
    if (in_item.op == OP_FORWARD) begin
      classified.g = '0;
    end
  end

  assign in_ready   = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign take       = pop && head_valid;
  assign head_valid = (count != '0);
  assign head_item  = slot[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= classified;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, take})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/silu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module silu_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             head_valid,
  input  wire silu_pkg::item_t                  head_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [silu_pkg::DATA_WIDTH-1:0]       out_y,
  output logic                                  out_sat
);
  import silu_pkg::*;

  logic en;

  // stage a: table lookup
  logic [DATA_WIDTH-1:0]        ax;
  logic [POS_W-1:0]             pos;
  logic [POS_W-1:0]             idx_full;
  logic                         beyond;
  logic [IDX_W-1:0]             idx_lo;
  logic [IDX_W-1:0]             idx_hi;
  logic [KNOT_W-1:0]            knot_lo;
  logic [KNOT_W-1:0]            knot_hi;
  logic                         a_valid;
  logic [KNOT_W-1:0]            a_lo;
  logic [KNOT_W-1:0]            a_diff;
  logic [SPAN_SHIFT-1:0]        a_frac;
  logic                         a_neg;
  op_t                          a_op;
  logic signed [DATA_WIDTH-1:0] a_x;
  logic signed [DATA_WIDTH-1:0] a_g;

  // stage b: interpolation
  logic [KNOT_W+SPAN_SHIFT-1:0] interp_prod;
  logic [S_W-1:0]               s_pos;
  logic                         b_valid;
  logic [S_W-1:0]               b_s;
  op_t                          b_op;
  logic signed [DATA_WIDTH-1:0] b_x;
  logic signed [DATA_WIDTH-1:0] b_g;

  // stage c: silu product and sigmoid slope product
  logic                         c_valid;
  logic signed [FWD_W-1:0]      c_fwd_prod;
  logic [SIGP_W-1:0]            c_sig_prod;
  logic [S_W-1:0]               c_s;
  op_t                          c_op;
  logic signed [DATA_WIDTH-1:0] c_x;
  logic signed [DATA_WIDTH-1:0] c_g;

  // stage d: slope rounding and x times slope
  logic [SIGP_W:0]              sp_sum;
  logic [S_W-1:0]               sp;
  logic signed [WIDE_W-1:0]     y_fwd_wide;
  logic                         d_valid;
  logic signed [DATA_WIDTH:0]   d_y_fwd;
  logic signed [TPROD_W-1:0]    d_tprod;
  logic [S_W-1:0]               d_s;
  op_t                          d_op;
  logic signed [DATA_WIDTH-1:0] d_g;

  // stage e: derivative and clamp
  logic signed [WIDE_W-1:0]     t_wide;
  logic signed [TPROD_W:0]      deriv_wide;
  logic signed [D_W-1:0]        deriv_clamped;
  logic                         e_valid;
  logic signed [D_W-1:0]        e_deriv;
  logic signed [DATA_WIDTH:0]   e_y_fwd;
  op_t                          e_op;
  logic signed [DATA_WIDTH-1:0] e_g;

  // stage f: gradient product
  logic                         f_valid;
  logic signed [DG_W-1:0]       f_dg;
  logic signed [DATA_WIDTH:0]   f_y_fwd;
  op_t                          f_op;

  // output stage: rounding, selection, saturation
  logic signed [WIDE_W-1:0]     y_bwd_wide;
  logic signed [Y_W-1:0]        y_sel;
  logic                         y_hi;
  logic                         y_lo;

  // whole pipeline moves while the output slot is free or being taken
  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  // |x| position in the table
  always_comb begin
    ax       = head_item.x[DATA_WIDTH-1] ? DATA_WIDTH'(-head_item.x)
                                         : DATA_WIDTH'(head_item.x);
    pos      = POS_W'(ax) * POS_W'(SIGMOID_SEGMENTS);
    idx_full = pos >> SPAN_SHIFT;
    beyond   = (idx_full >= POS_W'(SIGMOID_SEGMENTS));
    idx_lo   = beyond ? IDX_W'(SIGMOID_SEGMENTS) : idx_full[IDX_W-1:0];
    idx_hi   = beyond ? IDX_W'(SIGMOID_SEGMENTS) : idx_full[IDX_W-1:0] + IDX_W'(1);
    knot_lo  = KNOT_TABLE[idx_lo];
    knot_hi  = KNOT_TABLE[idx_hi];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lo   <= knot_lo;
      a_diff <= (knot_hi > knot_lo) ? knot_hi - knot_lo : '0;
      a_frac <= pos[SPAN_SHIFT-1:0];
      a_neg  <= head_item.x[DATA_WIDTH-1];
      a_op   <= head_item.op;
      a_x    <= head_item.x;
      a_g    <= head_item.g;
    end
  end

  // linear interpolation, mirrored for negative x
  always_comb begin
    interp_prod = (KNOT_W + SPAN_SHIFT)'(a_diff) * (KNOT_W + SPAN_SHIFT)'(a_frac);
    s_pos       = S_W'(a_lo) + S_W'(interp_prod >> SPAN_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_s  <= a_neg ? SIG_ONE - s_pos : s_pos;
      b_op <= a_op;
      b_x  <= a_x;
      b_g  <= a_g;
    end
  end

  // x * s and s * (1 - s)
  always_ff @(posedge clk) begin
    if (en) begin
      c_fwd_prod <= FWD_W'(b_x) * FWD_W'($signed({1'b0, b_s}));
      c_sig_prod <= SIGP_W'(b_s) * SIGP_W'(SIG_ONE - b_s);
      c_s        <= b_s;
      c_op       <= b_op;
      c_x        <= b_x;
      c_g        <= b_g;
    end
  end

  // round the slope, then scale it by x
  always_comb begin
    sp_sum     = (SIGP_W + 1)'(c_sig_prod) + (SIGP_W + 1)'(64'd1 << (SIG_BITS - 1));
    sp         = S_W'(sp_sum >> SIG_BITS);
    y_fwd_wide = round_shr(WIDE_W'(c_fwd_prod), SIG_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_y_fwd <= y_fwd_wide[DATA_WIDTH:0];
      d_tprod <= TPROD_W'(c_x) * TPROD_W'($signed({1'b0, sp}));
      d_s     <= c_s;
      d_op    <= c_op;
      d_g     <= c_g;
    end
  end

  // derivative = s + x*s*(1-s), held to plus or minus two
  always_comb begin
    t_wide     = round_shr(WIDE_W'(d_tprod), FRAC_BITS);
    deriv_wide = (TPROD_W + 1)'($signed(t_wide[TPROD_W-1:0])) +
                 (TPROD_W + 1)'($signed({1'b0, d_s}));
    priority if (deriv_wide > (TPROD_W + 1)'(DERIV_MAX)) begin
      deriv_clamped = DERIV_MAX;
    end else if (deriv_wide < (TPROD_W + 1)'(DERIV_MIN)) begin
      deriv_clamped = DERIV_MIN;
    end else begin
      deriv_clamped = deriv_wide[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_deriv <= deriv_clamped;
      e_y_fwd <= d_y_fwd;
      e_op    <= d_op;
      e_g     <= d_g;
    end
  end

  // derivative times gradient
  always_ff @(posedge clk) begin
    if (en) begin
      f_dg    <= DG_W'(e_deriv) * DG_W'(e_g);
      f_y_fwd <= e_y_fwd;
      f_op    <= e_op;
    end
  end

  // pick the mode result and saturate
  always_comb begin
    y_bwd_wide = round_shr(WIDE_W'(f_dg), SIG_BITS);
    unique case (f_op)
      OP_FORWARD:  y_sel = Y_W'(f_y_fwd);
      OP_BACKWARD: y_sel = y_bwd_wide[Y_W-1:0];
      default:     y_sel = Y_W'(f_y_fwd);
    endcase
    y_hi = (y_sel > Y_W'(DATA_MAX));
    y_lo = (y_sel < Y_W'(DATA_MIN));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (y_hi) begin
        out_y <= DATA_MAX;
      end else if (y_lo) begin
        out_y <= DATA_MIN;
      end else begin
        out_y <= y_sel[DATA_WIDTH-1:0];
      end
      out_sat <= y_hi || y_lo;
    end
  end

  // stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= head_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      f_valid   <= e_valid;
      out_valid <= f_valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/silu_activation_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Throughput: one item per cycle while the output is not stalled; a 4-entry queue sits
// between intake and the 7-stage arithmetic pipeline, and the pipeline advances whenever
// its output register is free or being taken.
// Reset (rst, synchronous, active high) empties the queue and clears all stage valids;
// the sigmoid knot table is constant, so the unit is ready the cycle after reset.
module silu_activation_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_value [15:0], grad_in [31:16]
  input  wire logic [silu_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  // opcode [0]
  input  wire logic [0:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // y_value [15:0]
  output logic [silu_pkg::TDATA_OUT_W-1:0]      m_axis_tdata,
  // saturated [0]
  output logic [0:0]                            m_axis_tuser
);
  import silu_pkg::*;

  item_t                 in_item;
  item_t                 head_item;
  logic                  head_valid;
  logic                  pop;
  logic [DATA_WIDTH-1:0] out_y;
  logic                  out_sat;

  // unpack the input transaction
  always_comb begin
    in_item.op = op_t'(s_axis_tuser[0]);
    in_item.x  = s_axis_tdata[DATA_WIDTH-1:0];
    in_item.g  = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
  end

  silu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  silu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_y      (out_y),
    .out_sat    (out_sat)
  );

  // pack the output transaction
  assign m_axis_tdata = TDATA_OUT_W'(out_y);
  assign m_axis_tuser = out_sat;

endmodule

`default_nettype wire

@@ rtl/core/silu_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module silu_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_axis_tready,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [silu_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input wire logic [0:0]                       m_axis_tuser
);
  import silu_pkg::*;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // the saturation flag only comes with a range limit value
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[DATA_WIDTH-1:0] == DATA_MAX) ||
      (m_axis_tdata[DATA_WIDTH-1:0] == DATA_MIN))
    else $error("saturation flag set on an in-range value");

  // reset leaves an empty pipeline that can take input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("unit not empty and ready after reset");

endmodule

bind silu_activation_unit silu_checker u_silu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/sv/silu_activation_unit_tb.sv @@
`timescale 1ns / 1ps

module silu_activation_unit_tb;
  import silu_pkg::*;

  localparam int     WATCHDOG_LIMIT   = 4000;
  localparam int     DRAIN_CYCLES     = 20;
  localparam int     ITEMS_PER_PHASE  = 350;
  localparam int     HOLD_OFF_CYCLES  = 120;
  localparam longint SIG_UNIT         = longint'(1) << SIG_BITS;

  typedef struct {
    logic signed [DATA_WIDTH-1:0] y;
    logic                         sat;
  } silu_result_t;

  // expected silu results, predicted from the accepted samples
  class silu_result_checker;
    longint       sig_knot [SIGMOID_SEGMENTS + 1];
    silu_result_t expected_results [$];
    int           mismatch_count;

    function new();
      mismatch_count = 0;
      fill_sig_knots();
    endfunction

    // knot values of the sigmoid in q30 from a truncated exp series
    function void fill_sig_knots();
      longint step_q30;
      longint term;
      longint acc;
      longint e;
      longint q;
      longint d;
      step_q30 = ((longint'(8) << SIG_BITS) + SIGMOID_SEGMENTS / 2) / SIGMOID_SEGMENTS;
      term     = SIG_UNIT;
      acc      = SIG_UNIT;
      e        = SIG_UNIT;
      for (int n = 1; n < 64 && term != 0; n++) begin
        term = ((term * step_q30) >> SIG_BITS) / n;
        acc  = (n % 2 == 1) ? acc - term : acc + term;
      end
      q = (acc < 0) ? 0 : acc;
      for (int k = 0; k <= SIGMOID_SEGMENTS; k++) begin
        if (k > 0) begin
          e = (e * q + (longint'(1) << (SIG_BITS - 1))) >> SIG_BITS;
        end
        d           = SIG_UNIT + e;
        sig_knot[k] = ((longint'(1) << (2 * SIG_BITS)) + d / 2) / d;
      end
    endfunction

    // right shift rounding half away from zero
    function longint round_half_away(longint v, int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (sh - 1))) >> sh;
      return (v < 0) ? -m : m;
    endfunction

    // interpolated sigmoid over |x|, mirrored for negative samples
    function longint sigmoid_at(longint xv);
      longint ax;
      longint pos;
      longint idx;
      longint frac;
      longint diff;
      longint s;
      ax   = (xv < 0) ? -xv : xv;
      pos  = ax * SIGMOID_SEGMENTS;
      idx  = pos >> SPAN_SHIFT;
      frac = pos & ((longint'(1) << SPAN_SHIFT) - 1);
      if (idx >= SIGMOID_SEGMENTS) begin
        s = sig_knot[SIGMOID_SEGMENTS];
      end else begin
        diff = sig_knot[idx + 1] - sig_knot[idx];
        if (diff < 0) diff = 0;
        s = sig_knot[idx] + ((diff * frac) >> SPAN_SHIFT);
      end
      return (xv < 0) ? SIG_UNIT - s : s;
    endfunction

    function silu_result_t predict_silu(op_t op, logic signed [DATA_WIDTH-1:0] x,
                                        logic signed [DATA_WIDTH-1:0] g);
      longint       xv;
      longint       gv;
      longint       s;
      longint       slope;
      longint       t;
      longint       deriv;
      longint       y;
      silu_result_t r;
      xv = x;
      gv = g;
      s  = sigmoid_at(xv);
      if (op == OP_FORWARD) begin
        y = round_half_away(xv * s, SIG_BITS);
      end else begin
        slope = (s * (SIG_UNIT - s) + (longint'(1) << (SIG_BITS - 1))) >> SIG_BITS;
        t     = round_half_away(xv * slope, FRAC_BITS);
        deriv = s + t;
        if (deriv > 2 * SIG_UNIT) deriv = 2 * SIG_UNIT;
        if (deriv < -2 * SIG_UNIT) deriv = -2 * SIG_UNIT;
        y = round_half_away(deriv * gv, SIG_BITS);
      end
      r.sat = 1'b0;
      if (y > longint'(DATA_MAX)) begin
        y     = DATA_MAX;
        r.sat = 1'b1;
      end
      if (y < longint'(DATA_MIN)) begin
        y     = DATA_MIN;
        r.sat = 1'b1;
      end
      r.y = y[DATA_WIDTH-1:0];
      return r;
    endfunction

    function void note_input(op_t op, logic signed [DATA_WIDTH-1:0] x,
                             logic signed [DATA_WIDTH-1:0] g);
      expected_results.push_back(predict_silu(op, x, g));
    endfunction

    task report_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    task check_result(logic signed [DATA_WIDTH-1:0] y, logic sat);
      silu_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result y=%0d sat=%0b with nothing outstanding", y, sat));
      end else begin
        want = expected_results.pop_front();
        if (y !== want.y)
          report_mismatch($sformatf("y_value got %0d want %0d", y, want.y));
        if (sat !== want.sat)
          report_mismatch($sformatf("saturated got %0b want %0b (y=%0d)", sat, want.sat,
                                    want.y));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic [0:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  silu_result_checker results_chk;
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 hold_left = 0;

  silu_activation_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // offer one sample, with random idle cycles ahead of it
  task automatic send_item(input op_t op, input logic [DATA_WIDTH-1:0] x,
                           input logic [DATA_WIDTH-1:0] g);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {g, x};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    results_chk.note_input(op, x, g);
  endtask

  // samples biased towards small values, knot points and the range ends
  function automatic logic [DATA_WIDTH-1:0] pick_sample();
    int v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = int'($urandom_range(16383)) - 8192;
      2: v = $urandom_range(1) ? 32767 - int'($urandom_range(63))
                               : -32768 + int'($urandom_range(63));
      default: v = (int'($urandom_range(127)) - 64) * 512 + int'($urandom_range(4)) - 2;
    endcase
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_gradient();
    if ($urandom_range(1)) return DATA_WIDTH'($urandom);
    return DATA_WIDTH'(int'($urandom_range(8191)) - 4096);
  endfunction

  task automatic send_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(op_t'($urandom_range(1)), pick_sample(), pick_gradient());
    end
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      results_chk.check_result(m_axis_tdata[DATA_WIDTH-1:0], m_axis_tuser[0]);
  end

  // watchdog on cycles without any transaction
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("silu_activation_unit_tb failed");
    $finish;
  end

  // main sequence
  initial begin
    results_chk = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: range ends, knot points, saturation both ways
    send_item(OP_FORWARD, 16'sd0, 16'sd0);
    send_item(OP_FORWARD, 16'sd1, 16'sd100);
    send_item(OP_FORWARD, -16'sd1, -16'sd100);
    send_item(OP_FORWARD, 16'sd32767, 16'sd32767);
    send_item(OP_FORWARD, -16'sd32768, -16'sd32768);
    send_item(OP_FORWARD, 16'sd512, 16'sd0);
    send_item(OP_FORWARD, -16'sd512, 16'sd0);
    send_item(OP_FORWARD, 16'sd4096, 16'sd0);
    send_item(OP_FORWARD, -16'sd4096, 16'sd0);
    send_item(OP_FORWARD, 16'sd20000, -16'sd32768);
    send_item(OP_BACKWARD, 16'sd0, 16'sd4096);
    send_item(OP_BACKWARD, 16'sd32767, 16'sd32767);
    send_item(OP_BACKWARD, -16'sd32768, 16'sd32767);
    send_item(OP_BACKWARD, -16'sd32768, -16'sd32768);
    send_item(OP_BACKWARD, 16'sd9830, 16'sd32767);
    send_item(OP_BACKWARD, 16'sd9830, -16'sd32768);
    send_item(OP_BACKWARD, -16'sd1, 16'sd1);
    send_item(OP_BACKWARD, 16'sd4096, -16'sd4096);
    send_item(OP_BACKWARD, 16'sd1024, 16'sd0);
    send_item(OP_BACKWARD, -16'sd9830, 16'sd32767);
    send_item(OP_BACKWARD, 16'sd512, -16'sd32768);

    // full rate, with one long receiver hold-off to back up the pipeline
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = HOLD_OFF_CYCLES;
    send_random_items(ITEMS_PER_PHASE);

    // sparse sender
    send_idle_pct = 57;
    stall_pct     = 0;
    send_random_items(ITEMS_PER_PHASE);

    // stalling receiver
    send_idle_pct = 0;
    stall_pct     = 57;
    send_random_items(ITEMS_PER_PHASE);

    // both sides idling
    send_idle_pct = 35;
    stall_pct     = 35;
    send_random_items(ITEMS_PER_PHASE);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // drain
    while (results_chk.expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_chk.expected_results.size() > 0)
      results_chk.report_mismatch("results still outstanding at the end");

    if (results_chk.mismatch_count == 0) begin
      $display("silu_activation_unit_tb passed");
    end else begin
      $display("silu_activation_unit_tb failed");
    end
    $finish;
  end

endmodule
